### hdl/anc_pkg.sv
// shared types and constants of the arp neighbour cache
package anc_pkg;

  localparam int HANDLE_W  = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [31:0] LOCAL_IP_RST = 32'd40020160;
  localparam logic [31:0] NET_MASK_RST = 32'd16777215;
  localparam logic [31:0] GATEWAY_RST  = 32'd23242944;

  localparam logic [31:0] BCAST_IP  = 32'hffff_ffff;
  localparam logic [47:0] BCAST_MAC = 48'hffff_ffff_ffff;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NET_MASK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY_IP = 2'd2;

  localparam logic ACT_SEND   = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_PENDING = 2'd1;
  localparam logic [1:0] ST_VALID   = 2'd2;

  typedef enum logic [1:0] {
    KIND_TX  = 2'd0,
    KIND_ARP = 2'd1,
    KIND_REL = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WB,
    S_EMIT,
    S_SHPRE,
    S_SHIFT,
    S_FRONT
  } state_t;

  typedef struct packed {
    logic [31:0] local_ip;
    logic [31:0] net_mask;
    logic [31:0] gateway_ip;
  } cfg_t;

  typedef struct packed {
    kind_t                kind;
    logic [HANDLE_W-1:0]  handle;
    logic [47:0]          mac;
    logic [31:0]          ip;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic idle;
    logic push;
    logic push_last;
  } stat_t;

endpackage

### hdl/anc_ifs.sv
// handshake channel interfaces of the arp neighbour cache
interface anc_cmd_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [31:0]                   ip_addr;
  logic [47:0]                   mac_addr;
  logic [anc_pkg::HANDLE_W-1:0]  pkt_handle;
  modport source (output valid, action, ip_addr, mac_addr, pkt_handle, input ready);
  modport sink (input valid, action, ip_addr, mac_addr, pkt_handle, output ready);
endinterface

interface anc_res_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [anc_pkg::HANDLE_W-1:0]  out_handle;
  logic [47:0]                   dest_mac;
  logic [31:0]                   target_ip;
  logic                          last;
  modport source (output valid, kind, out_handle, dest_mac, target_ip, last, input ready);
  modport sink (input valid, kind, out_handle, dest_mac, target_ip, last, output ready);
endinterface

interface anc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [anc_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/anc_ram.sv
// generic single-write, single-read ram with registered read data
module anc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/anc_outq.sv
// two-item result queue between the controller and the result channel
module anc_outq (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_vld,
  input  anc_pkg::res_t   push_res,
  output logic            push_rdy,
  anc_res_if.source       res
);

  anc_pkg::res_t slot [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;

  assign push_rdy = (count != 2'd2);
  assign push     = push_vld && push_rdy;
  assign pop      = res.valid && res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= push_res;
    end
  end

  assign res.valid      = (count != 2'd0);
  assign res.kind       = slot[rptr].kind;
  assign res.out_handle = slot[rptr].handle;
  assign res.dest_mac   = slot[rptr].mac;
  assign res.target_ip  = slot[rptr].ip;
  assign res.last       = slot[rptr].last;

endmodule

### hdl/anc_ctrl.sv
// lookup, write-back and recency controller around the entry and order rams
module anc_ctrl #(
  parameter int ENTRIES     = 8,
  parameter int HANDLE_BITS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  anc_pkg::cfg_t    cfg_regs,
  anc_cmd_if.sink          cmd,
  output logic             push_vld,
  output anc_pkg::res_t    push_res,
  input  logic             push_rdy,
  output anc_pkg::stat_t   stat
);

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST_POS = IW'(ENTRIES - 1);

  typedef struct packed {
    logic [31:0]            ip;
    logic [47:0]            mac;
    logic [1:0]             status;
    logic [HANDLE_BITS-1:0] parked;
  } ent_t;

  localparam int EW = $bits(ent_t);

  anc_pkg::state_t state;
  anc_pkg::state_t state_next;

  logic                     act_q;
  logic [31:0]              ip_q;
  logic [47:0]              mac_q;
  logic [HANDLE_BITS-1:0]   hnd_q;
  logic                     bcast_q;

  logic [IW-1:0]            ra_pos;
  logic                     iss;
  logic                     a_vld;
  logic [IW-1:0]            a_pos;
  logic                     b_vld;
  logic [IW-1:0]            b_pos;
  logic [IW-1:0]            b_e;
  logic                     hit_q;
  logic [IW-1:0]            pos_q;
  logic [IW-1:0]            e_q;
  ent_t                     ent_q;
  logic                     k_q;
  logic [IW-1:0]            wp;

  logic [ENTRIES-1:0]       ent_vld;
  logic [ENTRIES-1:0]       ord_vld;

  logic [IW-1:0]            ord_raddr;
  logic [IW-1:0]            ord_raddr_q;
  logic [IW-1:0]            ord_rdata;
  logic [IW-1:0]            ord_sub;
  logic                     ord_we;
  logic [IW-1:0]            ord_waddr;
  logic [IW-1:0]            ord_wdata;

  logic [EW-1:0]            ent_rdata;
  ent_t                     ent_sub;
  logic                     ent_we;
  ent_t                     ent_wdata;

  logic [HANDLE_BITS-1:0]   hnd_in;
  logic [anc_pkg::HANDLE_W-1:0] hnd_out;
  logic [anc_pkg::HANDLE_W-1:0] pk_out;
  logic [31:0]              nh;
  logic                     accept;
  logic                     match;
  logic                     c_done;
  logic                     st_pend;
  logic                     st_valid;
  logic                     mv;
  logic                     wb_need;
  logic [1:0]               n_res;
  anc_pkg::res_t            res_a;
  anc_pkg::res_t            res_b;
  anc_pkg::state_t          after_emit;

  // handle width conversion
  for (genvar gi = 0; gi < HANDLE_BITS; gi++) begin : g_hin
    if (gi < anc_pkg::HANDLE_W) begin : g_b
      assign hnd_in[gi] = cmd.pkt_handle[gi];
    end else begin : g_z
      assign hnd_in[gi] = 1'b0;
    end
  end

  for (genvar go = 0; go < anc_pkg::HANDLE_W; go++) begin : g_hout
    if (go < HANDLE_BITS) begin : g_b
      assign hnd_out[go] = hnd_q[go];
      assign pk_out[go]  = ent_q.parked[go];
    end else begin : g_z
      assign hnd_out[go] = 1'b0;
      assign pk_out[go]  = 1'b0;
    end
  end

  anc_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_ord_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  anc_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (e_q),
    .wdata (ent_wdata),
    .raddr (ord_sub),
    .rdata (ent_rdata)
  );

  // next hop: gateway for off-subnet destinations
  assign nh = ((cmd.ip_addr & cfg_regs.net_mask) != (cfg_regs.local_ip & cfg_regs.net_mask))
              ? cfg_regs.gateway_ip : cmd.ip_addr;
  assign accept = cmd.valid && cmd.ready;

  // unwritten order slots hold their own position, unwritten entries read as zero
  assign ord_sub = ord_vld[ord_raddr_q] ? ord_rdata : ord_raddr_q;
  assign ent_sub = ent_vld[b_e] ? ent_t'(ent_rdata) : '0;
  assign match   = (ent_sub.ip == ip_q);
  assign c_done  = b_vld && (match || (b_pos == LAST_POS));

  assign st_pend  = (ent_q.status == anc_pkg::ST_PENDING);
  assign st_valid = (ent_q.status == anc_pkg::ST_VALID);
  assign mv       = !bcast_q && (((act_q == anc_pkg::ACT_SEND) && !hit_q)
                    || ((act_q == anc_pkg::ACT_UPDATE) && hit_q));
  assign wb_need  = ((act_q == anc_pkg::ACT_SEND) && !(hit_q && st_valid))
                    || ((act_q == anc_pkg::ACT_UPDATE) && hit_q);

  always_comb begin
    if (!mv) begin
      after_emit = anc_pkg::S_IDLE;
    end else if (pos_q == '0) begin
      after_emit = anc_pkg::S_FRONT;
    end else begin
      after_emit = anc_pkg::S_SHPRE;
    end
  end

  // results of the item
  always_comb begin
    res_a = '0;
    res_b = '0;
    n_res = 2'd0;
    if (act_q == anc_pkg::ACT_SEND) begin
      if (bcast_q) begin
        res_a.kind   = anc_pkg::KIND_TX;
        res_a.handle = hnd_out;
        res_a.mac    = anc_pkg::BCAST_MAC;
        n_res        = 2'd1;
      end else if (hit_q && st_valid) begin
        res_a.kind   = anc_pkg::KIND_TX;
        res_a.handle = hnd_out;
        res_a.mac    = ent_q.mac;
        n_res        = 2'd1;
      end else if (st_pend) begin
        res_a.kind   = anc_pkg::KIND_REL;
        res_a.handle = pk_out;
        res_b.kind   = anc_pkg::KIND_ARP;
        res_b.ip     = ip_q;
        n_res        = 2'd2;
      end else begin
        res_a.kind   = anc_pkg::KIND_ARP;
        res_a.ip     = ip_q;
        n_res        = 2'd1;
      end
    end else if (hit_q && st_pend) begin
      res_a.kind   = anc_pkg::KIND_TX;
      res_a.handle = pk_out;
      res_a.mac    = mac_q;
      n_res        = 2'd1;
    end
  end

  always_comb begin
    push_res      = k_q ? res_b : res_a;
    push_res.last = k_q || (n_res == 2'd1);
  end

  always_comb begin
    if (act_q == anc_pkg::ACT_SEND) begin
      ent_wdata.ip     = ip_q;
      ent_wdata.mac    = ent_q.mac;
      ent_wdata.status = anc_pkg::ST_PENDING;
      ent_wdata.parked = hnd_q;
    end else begin
      ent_wdata.ip     = ent_q.ip;
      ent_wdata.mac    = mac_q;
      ent_wdata.status = anc_pkg::ST_VALID;
      ent_wdata.parked = ent_q.parked;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      anc_pkg::S_IDLE: begin
        if (cmd.valid) begin
          if ((cmd.action == anc_pkg::ACT_SEND) && (nh == anc_pkg::BCAST_IP)) begin
            state_next = anc_pkg::S_EMIT;
          end else begin
            state_next = anc_pkg::S_SCAN;
          end
        end
      end
      anc_pkg::S_SCAN: begin
        if (c_done) begin
          state_next = anc_pkg::S_WB;
        end
      end
      anc_pkg::S_WB: begin
        if (n_res != 2'd0) begin
          state_next = anc_pkg::S_EMIT;
        end else begin
          state_next = after_emit;
        end
      end
      anc_pkg::S_EMIT: begin
        if (push_rdy && (k_q || (n_res == 2'd1))) begin
          state_next = after_emit;
        end
      end
      anc_pkg::S_SHPRE: state_next = anc_pkg::S_SHIFT;
      anc_pkg::S_SHIFT: begin
        if (wp == IW'(1)) begin
          state_next = anc_pkg::S_FRONT;
        end
      end
      anc_pkg::S_FRONT: state_next = anc_pkg::S_IDLE;
      default: state_next = anc_pkg::S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    cmd.ready = 1'b0;
    push_vld  = 1'b0;
    ent_we    = 1'b0;
    ord_we    = 1'b0;
    ord_waddr = wp;
    ord_wdata = ord_sub;
    ord_raddr = ra_pos;
    unique case (state)
      anc_pkg::S_IDLE:  cmd.ready = 1'b1;
      anc_pkg::S_SCAN:  ord_raddr = ra_pos;
      anc_pkg::S_WB:    ent_we = wb_need;
      anc_pkg::S_EMIT:  push_vld = 1'b1;
      anc_pkg::S_SHPRE: ord_raddr = wp - IW'(1);
      anc_pkg::S_SHIFT: begin
        ord_we    = 1'b1;
        ord_raddr = (wp == IW'(1)) ? '0 : wp - IW'(2);
      end
      anc_pkg::S_FRONT: begin
        ord_we    = 1'b1;
        ord_waddr = '0;
        ord_wdata = e_q;
      end
      default: cmd.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= anc_pkg::S_IDLE;
      iss     <= 1'b0;
      a_vld   <= 1'b0;
      b_vld   <= 1'b0;
      k_q     <= 1'b0;
      ent_vld <= '0;
      ord_vld <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        iss   <= 1'b1;
        a_vld <= 1'b0;
        b_vld <= 1'b0;
        k_q   <= 1'b0;
      end else if (state == anc_pkg::S_SCAN) begin
        a_vld <= iss && !c_done;
        b_vld <= a_vld && !c_done;
        if (c_done || (iss && (ra_pos == LAST_POS))) begin
          iss <= 1'b0;
        end
      end
      if (push_vld && push_rdy) begin
        k_q <= ~k_q;
      end
      if (ent_we) begin
        ent_vld[e_q] <= 1'b1;
      end
      if (ord_we) begin
        ord_vld[ord_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ord_raddr_q <= ord_raddr;
    if (accept) begin
      act_q   <= cmd.action;
      ip_q    <= (cmd.action == anc_pkg::ACT_SEND) ? nh : cmd.ip_addr;
      mac_q   <= cmd.mac_addr;
      hnd_q   <= hnd_in;
      bcast_q <= (cmd.action == anc_pkg::ACT_SEND) && (nh == anc_pkg::BCAST_IP);
      ra_pos  <= '0;
    end
    if (state == anc_pkg::S_SCAN) begin
      if (iss && (ra_pos != LAST_POS)) begin
        ra_pos <= ra_pos + IW'(1);
      end
      a_pos <= ra_pos;
      b_pos <= a_pos;
      b_e   <= ord_sub;
      if (c_done) begin
        hit_q <= match;
        pos_q <= b_pos;
        e_q   <= b_e;
        ent_q <= ent_sub;
        wp    <= b_pos;
      end
    end
    if (state == anc_pkg::S_SHIFT) begin
      wp <= wp - IW'(1);
    end
  end

  assign stat.idle      = (state == anc_pkg::S_IDLE);
  assign stat.push      = push_vld && push_rdy;
  assign stat.push_last = push_res.last;

endmodule

### hdl/arp_neighbor_cache_lru.sv
// top level of the arp neighbour cache with move-to-front recency order
//
//  channel  role    payload
//  cfg      sink    index, data (local_ip, net_mask, gateway_ip)
//  cmd      sink    action, ip_addr, mac_addr, pkt_handle
//  res      source  kind, out_handle, dest_mac, target_ip, last
//
// one item at a time; a broadcast next hop skips the lookup and goes straight to its result
// lookup walks the order ram from the front until a hit or the last recency position,
// then a write-back step, the results, and, when an entry moves to the front, a rewrite
// of the order ram that shifts the entries ahead of it back by one and puts it at the front
// reset is immediate, valid bits stand in for the cleared entry and order rams
// a full two-item result queue holds the controller; cfg is always ready
module arp_neighbor_cache_lru #(
  parameter int ENTRIES     = 8,
  parameter int HANDLE_BITS = 8
) (
  input  logic      clk,
  input  logic      rst,
  anc_cfg_if.sink   cfg,
  anc_cmd_if.sink   cmd,
  anc_res_if.source res
);

  anc_pkg::cfg_t  cfg_q;
  anc_pkg::res_t  push_res;
  anc_pkg::stat_t stat;
  logic           push_vld;
  logic           push_rdy;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.local_ip   <= anc_pkg::LOCAL_IP_RST;
      cfg_q.net_mask   <= anc_pkg::NET_MASK_RST;
      cfg_q.gateway_ip <= anc_pkg::GATEWAY_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        anc_pkg::CFG_LOCAL_IP:   cfg_q.local_ip   <= cfg.data;
        anc_pkg::CFG_NET_MASK:   cfg_q.net_mask   <= cfg.data;
        anc_pkg::CFG_GATEWAY_IP: cfg_q.gateway_ip <= cfg.data;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  anc_ctrl #(.ENTRIES(ENTRIES), .HANDLE_BITS(HANDLE_BITS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_q),
    .cmd      (cmd),
    .push_vld (push_vld),
    .push_res (push_res),
    .push_rdy (push_rdy),
    .stat     (stat)
  );

  anc_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push_vld (push_vld),
    .push_res (push_res),
    .push_rdy (push_rdy),
    .res      (res)
  );

  // the controller is busy in the cycle after it accepts an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !stat.idle)
    else $error("controller idle right after accepting an item");

  // the first of two results never ends the item
  a_pair_holds_busy: assert property (@(posedge clk) disable iff (rst)
    stat.push && !stat.push_last |=> !stat.idle)
    else $error("controller left before the final result");

  // results are pushed only while the controller is at work
  a_push_busy: assert property (@(posedge clk) disable iff (rst)
    stat.push |-> !stat.idle && !cmd.ready)
    else $error("result pushed while idle");

endmodule
